[hw/rtl/wtg_pkg.sv]
// Shared constants, types and helper functions of the waveform table generator.
`timescale 1ns / 1ps

package wtg_pkg;

  // Waveform selector codes
  localparam logic [1:0] WF_SINE   = 2'd0;
  localparam logic [1:0] WF_SQUARE = 2'd1;
  localparam logic [1:0] WF_TRI    = 2'd2;

  // Register indexes of the configuration port
  localparam logic [1:0] CFG_WAVEFORM  = 2'd0;
  localparam logic [1:0] CFG_PERIOD    = 2'd1;
  localparam logic [1:0] CFG_AMPLITUDE = 2'd2;
  localparam logic [1:0] CFG_SIGNED    = 2'd3;

  localparam int unsigned MAX_PERIOD = 4096;
  localparam int unsigned RST_PERIOD = 256;
  localparam int unsigned RST_AMP    = 16384;
  localparam int unsigned RST_TIP    = (2 * RST_PERIOD + 5) / 10;

  // pi/2 in Q30
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

  // Divider geometry: 44-bit dividend, 14-bit divisor, 31 quotient bits
  localparam int unsigned NUM_W     = 44;
  localparam int unsigned DEN_W     = 14;
  localparam int unsigned DIV_STEPS = 31;

  // Pipeline map
  localparam int unsigned NUM_TERMS  = 6;
  localparam int unsigned STG_IDX    = 0;
  localparam int unsigned STG_QUAD   = 1;
  localparam int unsigned STG_NUM    = 2;
  localparam int unsigned STG_DIV0   = 3;
  localparam int unsigned STG_X2     = STG_DIV0 + DIV_STEPS;
  localparam int unsigned STG_TERM0  = STG_X2 + 1;
  localparam int unsigned STG_MAG    = STG_TERM0 + 3 * NUM_TERMS;
  localparam int unsigned STG_OUT    = STG_MAG + 1;
  localparam int unsigned NUM_STAGES = STG_OUT + 1;

  // Per-item side data that rides along the pipeline
  typedef struct packed {
    logic        oor;
    logic        neg;
    logic        sq_hi;
    logic [16:0] tri_q;
  } wtg_side_t;

  // Divisor (2k)(2k+1) of Taylor term k = idx+1
  function automatic logic [7:0] term_div(input logic [2:0] idx);
    logic [7:0] d;
    case (idx)
      3'd0:    d = 8'd6;
      3'd1:    d = 8'd20;
      3'd2:    d = 8'd42;
      3'd3:    d = 8'd72;
      3'd4:    d = 8'd110;
      3'd5:    d = 8'd156;
      default: d = 8'd6;
    endcase
    return d;
  endfunction

  // floor(2^32 / divisor), never overshoots the true quotient
  function automatic logic [29:0] term_recip(input logic [2:0] idx);
    logic [29:0] m;
    case (idx)
      3'd0:    m = 30'd715827882;
      3'd1:    m = 30'd214748364;
      3'd2:    m = 30'd102261126;
      3'd3:    m = 30'd59652323;
      3'd4:    m = 30'd39045157;
      3'd5:    m = 30'd27531841;
      default: m = 30'd715827882;
    endcase
    return m;
  endfunction

endpackage

[hw/rtl/waveform_table_generator.sv]
// Top level of the waveform table generator: config registers, pipeline and output buffer.
`timescale 1ns / 1ps

// Waveform table generator.
// Each request on the s_axis channel carries a sample index; the block answers
// with one sample of a sine, square or triangle period on m_axis, together with
// a flag in tuser that marks an index at or past the period length.
// Throughput: one request per clock while the output buffer has room. The
// depth is set by the 31-stage restoring divider (sine angle and triangle
// ramp share it) followed by six Taylor terms of three stages each (product,
// reciprocal multiply, correction).
// Configuration goes over the cfg channel (index, data); it is always ready and
// is to be written while no request is in flight.
// Reset clears the valid bits and the output buffer and loads the default
// registers: sine, period 256, amplitude 16384, signed mode.
// A two-entry output buffer sits after the pipeline. When the receiver stalls,
// results collect there; the pipeline keeps moving and s_axis_tready stays high
// until both entries are full, then the whole pipeline holds in place.
module waveform_table_generator import wtg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [11:0] sample_index
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // [16:0] sample_value
  output logic        m_axis_tuser   // [0] index_out_of_range
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [1:0]  wave_q;
  logic [12:0] period_q;
  logic [14:0] amp_q;
  logic        sgn_q;
  logic [12:0] tip_q;

  logic        cfg_we;
  logic [12:0] n_eff;
  logic [29:0] tip_prod;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_q   <= WF_SINE;
      period_q <= 13'(RST_PERIOD);
      amp_q    <= 15'(RST_AMP);
      sgn_q    <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index_i)
        CFG_WAVEFORM:  wave_q   <= cfg_data_i[1:0];
        CFG_PERIOD:    period_q <= cfg_data_i[12:0];
        CFG_AMPLITUDE: amp_q    <= cfg_data_i[14:0];
        CFG_SIGNED:    sgn_q    <= cfg_data_i[0];
        default:       wave_q   <= wave_q;
      endcase
    end
  end

  // Saturate the period, then hold the triangle tip round(N/5) = floor((2N+5)/10);
  // the /10 is a multiply by 52429 and a shift by 19, exact for these sizes.
  assign n_eff    = (period_q > 13'(MAX_PERIOD)) ? 13'(MAX_PERIOD) : period_q;
  assign tip_prod = 30'({n_eff, 1'b0} + 14'd5) * 30'd52429;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tip_q <= 13'(RST_TIP);
    end else begin
      tip_q <= 13'(tip_prod[29:19]);
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control: the whole pipeline advances together unless the buffer is full
  // ---------------------------------------------------------------------------
  logic [1:0] cnt_q;
  logic       en;

  assign en            = (cnt_q != 2'd2);
  assign s_axis_tready = en;

  logic [NUM_STAGES-1:0] v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NUM_STAGES-2:0], s_axis_tvalid};
    end
  end

  // ---------------------------------------------------------------------------
  // Side data carried along every stage
  // ---------------------------------------------------------------------------
  wtg_side_t side_q [NUM_STAGES];
  wtg_side_t side_d [NUM_STAGES];

  logic [11:0] idx_q;

  // divider quotient: sine angle or triangle ramp
  logic [DIV_STEPS-1:0] quo;

  // quadrant stage signals
  logic [13:0] f4, n2, r1, r0, rp_w;
  logic        ge1, ge0;
  logic        rise;
  logic [12:0] kk;
  logic [12:0] half;
  logic [28:0] ptri;

  logic [12:0] rp_q;
  logic        rise_q;
  logic [28:0] ptri_q;

  // quadrant: q = 4i / N in two compare-subtract steps, i < N so q < 4
  assign f4   = {idx_q, 2'b00};
  assign n2   = {n_eff, 1'b0};
  assign ge1  = f4 >= n2;
  assign r1   = ge1 ? f4 - n2 : f4;
  assign ge0  = r1 >= {1'b0, n_eff};
  assign r0   = ge0 ? r1 - {1'b0, n_eff} : r1;
  // mirror the angle in the odd quadrants
  assign rp_w = ge0 ? {1'b0, n_eff} - r0 : r0;

  // triangle ramp: rising part measures from zero, falling part from the end
  assign rise = {1'b0, idx_q} < tip_q;
  assign kk   = rise ? {1'b0, idx_q} : n_eff - {1'b0, idx_q};
  assign ptri = 29'({amp_q, 1'b0}) * 29'(kk);
  assign half = (n_eff + 13'd1) >> 1;

  always_comb begin
    for (int s = 0; s < NUM_STAGES; s++) begin
      if (s == 0) begin
        side_d[s]     = '0;
        side_d[s].oor = {1'b0, s_axis_tdata[11:0]} >= n_eff;
      end else begin
        side_d[s] = side_q[s-1];
      end
    end
    side_d[STG_QUAD].neg   = ge1;
    side_d[STG_QUAD].sq_hi = {1'b0, idx_q} < half;
    side_d[STG_X2].tri_q   = quo[16:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q <= side_d;
      idx_q  <= s_axis_tdata[11:0];
      rp_q   <= rp_w[12:0];
      rise_q <= rise;
      ptri_q <= ptri;
    end
  end

  // ---------------------------------------------------------------------------
  // Dividend and divisor: sine angle pi/2 * r' / N, or the rounded triangle ramp
  // ---------------------------------------------------------------------------
  logic [12:0]      hh;
  logic [29:0]      tri_num;
  logic [NUM_W-1:0] sin_num;
  logic [NUM_W-1:0] num_q;
  logic [DEN_W-1:0] den_q;

  assign hh      = rise_q ? tip_q : n_eff - tip_q;
  // round half up: (2*num + den) / (2*den)
  assign tri_num = 30'({ptri_q, 1'b0}) + 30'(hh);
  assign sin_num = NUM_W'(HALF_PI_Q30) * NUM_W'(rp_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (wave_q == WF_TRI) begin
        num_q <= NUM_W'(tri_num);
        den_q <= {hh, 1'b0};
      end else begin
        num_q <= sin_num;
        den_q <= {1'b0, n_eff};
      end
    end
  end

  wtg_div u_div (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (num_q),
    .den_i (den_q),
    .quo_o (quo)
  );

  // ---------------------------------------------------------------------------
  // Sine by Taylor series through x^13, all in Q30
  // ---------------------------------------------------------------------------
  logic [61:0] xx;
  logic [30:0] t_w   [NUM_TERMS+1];
  logic [31:0] x2_w  [NUM_TERMS+1];
  logic signed [33:0] sum_w [NUM_TERMS+1];

  logic [30:0]        x_q;
  logic [31:0]        x2_q;

  assign xx = 62'(quo) * 62'(quo);

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q  <= quo;
      x2_q <= xx[61:30];
    end
  end

  assign t_w[0]   = x_q;
  assign x2_w[0]  = x2_q;
  assign sum_w[0] = $signed({3'b000, x_q});

  for (genvar k = 0; k < NUM_TERMS; k++) begin : g_term
    wtg_sin_term u_term (
      .clk_i      (clk_i),
      .en_i       (en),
      .term_idx_i (3'(k)),
      .t_i        (t_w[k]),
      .x2_i       (x2_w[k]),
      .sum_i      (sum_w[k]),
      .t_o        (t_w[k+1]),
      .x2_o       (x2_w[k+1]),
      .sum_o      (sum_w[k+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Magnitude: clamp negative sums, scale by amplitude with round half up
  // ---------------------------------------------------------------------------
  logic [30:0] s_pos;
  logic [45:0] mprod;
  logic [15:0] mraw_q;

  assign s_pos = sum_w[NUM_TERMS][33] ? 31'd0 : sum_w[NUM_TERMS][30:0];
  assign mprod = 46'(amp_q) * 46'(s_pos) + 46'(1 << 29);

  always_ff @(posedge clk_i) begin
    if (en) begin
      mraw_q <= mprod[45:30];
    end
  end

  // ---------------------------------------------------------------------------
  // Final sample value per waveform and level shift
  // ---------------------------------------------------------------------------
  wtg_side_t   sd;
  logic [14:0] mag;
  logic signed [17:0] a18, m18, low, val;
  logic [16:0] res_q;
  logic        oor_q;

  assign sd  = side_q[STG_MAG];
  assign mag = (mraw_q > {1'b0, amp_q}) ? amp_q : mraw_q[14:0];
  assign a18 = $signed({3'b000, amp_q});
  assign m18 = $signed({3'b000, mag});
  assign low = sgn_q ? -a18 : 18'sd0;

  always_comb begin
    case (wave_q)
      WF_SINE: begin
        val = sd.neg ? -m18 : m18;
        if (!sgn_q) begin
          val = val + a18;
        end
      end
      WF_SQUARE: val = sd.sq_hi ? low + (a18 <<< 1) : low;
      WF_TRI:    val = low + $signed({1'b0, sd.tri_q});
      default:   val = 18'sd0;
    endcase
    if (sd.oor) begin
      val = 18'sd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= val[16:0];
      oor_q <= sd.oor;
    end
  end

  // ---------------------------------------------------------------------------
  // Two-entry output buffer
  // ---------------------------------------------------------------------------
  logic        push, pop;
  logic [16:0] hd_val_q, tl_val_q;
  logic        hd_oor_q, tl_oor_q;

  assign push = en & v_q[STG_OUT];
  assign pop  = m_axis_tvalid & m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (cnt_q == 2'd2) begin
        hd_val_q <= tl_val_q;
        hd_oor_q <= tl_oor_q;
        if (push) begin
          tl_val_q <= res_q;
          tl_oor_q <= oor_q;
        end
      end else if (push) begin
        hd_val_q <= res_q;
        hd_oor_q <= oor_q;
      end
    end else if (push) begin
      if (cnt_q == 2'd0) begin
        hd_val_q <= res_q;
        hd_oor_q <= oor_q;
      end else begin
        tl_val_q <= res_q;
        tl_oor_q <= oor_q;
      end
    end
  end

  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign m_axis_tdata  = {7'd0, hd_val_q};
  assign m_axis_tuser  = hd_oor_q;

endmodule

[hw/rtl/wtg_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps

module wtg_div import wtg_pkg::*; (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [NUM_W-1:0]     num_i,
  input  logic [DEN_W-1:0]     den_i,
  output logic [DIV_STEPS-1:0] quo_o
);

  logic [DEN_W-1:0]     rem_q [DIV_STEPS];
  logic [DEN_W-1:0]     den_q [DIV_STEPS];
  logic [DIV_STEPS-1:0] nlo_q [DIV_STEPS];
  logic [DIV_STEPS-1:0] quo_q [DIV_STEPS];

  logic [DEN_W-1:0]     rem_d [DIV_STEPS];
  logic [DEN_W-1:0]     den_d [DIV_STEPS];
  logic [DIV_STEPS-1:0] nlo_d [DIV_STEPS];
  logic [DIV_STEPS-1:0] quo_d [DIV_STEPS];

  always_comb begin
    for (int j = 0; j < DIV_STEPS; j++) begin
      logic [DEN_W-1:0]     rem_in;
      logic [DEN_W-1:0]     den_in;
      logic [DIV_STEPS-1:0] nlo_in;
      logic [DIV_STEPS-1:0] quo_in;
      logic [DEN_W:0]       trial;
      logic                 ge;
      if (j == 0) begin
        rem_in = DEN_W'(num_i[NUM_W-1:DIV_STEPS]);
        den_in = den_i;
        nlo_in = num_i[DIV_STEPS-1:0];
        quo_in = '0;
      end else begin
        rem_in = rem_q[j-1];
        den_in = den_q[j-1];
        nlo_in = nlo_q[j-1];
        quo_in = quo_q[j-1];
      end
      // bring down the next dividend bit, subtract when it fits
      trial    = {rem_in, nlo_in[DIV_STEPS-1]};
      ge       = trial >= {1'b0, den_in};
      rem_d[j] = ge ? DEN_W'(trial - {1'b0, den_in}) : DEN_W'(trial);
      den_d[j] = den_in;
      nlo_d[j] = {nlo_in[DIV_STEPS-2:0], 1'b0};
      quo_d[j] = {quo_in[DIV_STEPS-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      den_q <= den_d;
      nlo_q <= nlo_d;
      quo_q <= quo_d;
    end
  end

  assign quo_o = quo_q[DIV_STEPS-1];

endmodule

[hw/rtl/wtg_sin_term.sv]
// One Taylor term of the sine series in three stages: product, reciprocal, correction.
`timescale 1ns / 1ps

module wtg_sin_term import wtg_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [2:0]         term_idx_i,
  input  logic [30:0]        t_i,
  input  logic [31:0]        x2_i,
  input  logic signed [33:0] sum_i,
  output logic [30:0]        t_o,
  output logic [31:0]        x2_o,
  output logic signed [33:0] sum_o
);

  logic [7:0]  dv;
  logic [29:0] recip;
  logic [62:0] prod_a;
  logic [61:0] prod_b;
  logic [32:0] qd;
  logic [32:0] rem;
  logic [30:0] tq;

  logic [31:0]        p_a_q, p_b_q;
  logic [31:0]        x2_a_q, x2_b_q, x2_c_q;
  logic signed [33:0] sum_a_q, sum_b_q, sum_c_q;
  logic [29:0]        q0_b_q;
  logic [30:0]        t_c_q;

  assign dv     = term_div(term_idx_i);
  assign recip  = term_recip(term_idx_i);
  assign prod_a = 63'(t_i) * 63'(x2_i);
  assign prod_b = 62'(p_a_q) * 62'(recip);
  assign qd     = 33'(q0_b_q) * 33'(dv);
  assign rem    = {1'b0, p_b_q} - qd;
  // the reciprocal estimate is low by at most one
  assign tq     = {1'b0, q0_b_q} + 31'(rem >= 33'(dv));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_a_q   <= prod_a[61:30];
      x2_a_q  <= x2_i;
      sum_a_q <= sum_i;

      q0_b_q  <= prod_b[61:32];
      p_b_q   <= p_a_q;
      x2_b_q  <= x2_a_q;
      sum_b_q <= sum_a_q;

      t_c_q   <= tq;
      x2_c_q  <= x2_b_q;
      sum_c_q <= term_idx_i[0] ? sum_b_q + $signed({3'b000, tq})
                               : sum_b_q - $signed({3'b000, tq});
    end
  end

  assign t_o   = t_c_q;
  assign x2_o  = x2_c_q;
  assign sum_o = sum_c_q;

endmodule

[bench/waveform_table_generator_test.sv]
// Self-checking bench for the waveform table generator: directed table, then random phases.
`timescale 1ns / 1ps

// Drives sample-index requests into the generator and checks every result against
// a table value or an in-bench model of sine, square and triangle arithmetic.
// A short directed table hits the register extremes, the out-of-range flag,
// the saturated and degenerate periods and the unused waveform code. Random
// phases follow, each under a fresh register setting. Both stream sides idle
// at random. One long receiver stall fills the pipeline and stalls the input.
module waveform_table_generator_test import wtg_pkg::*; ();

  localparam int PHASES     = 10;
  localparam int PHASE_REQS = 50;
  localparam int HOLD_PHASE = 4;
  localparam int HOLD_REQS  = 100;
  localparam int IDLE_LIMIT = 5000;
  localparam int TAIL_WAIT  = 80;
  localparam int LONG_HOLD  = 300;
  localparam int MAX_SHOWN  = 10;

  localparam logic ROW_REQ = 1'b0;
  localparam logic ROW_CFG = 1'b1;

  typedef struct {
    logic [16:0] value;
    logic        oor;
  } sample_t;

  typedef struct {
    logic        kind;
    logic [1:0]  cfg_reg;
    logic [15:0] cfg_val;
    logic [11:0] index;
    logic        typed;
    int          value;
    logic        oor;
  } row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [15:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;

  // mirror of the block's registers, updated on each accepted config write
  logic [1:0]  wave_sel;
  logic [12:0] period_reg;
  logic [14:0] amp_reg;
  logic        centered;

  sample_t     sample_q[$];
  sample_t     cur_sample;
  logic        cur_typed;
  int          mismatches;
  int          req_count;
  int          res_count;
  int          cfg_count;
  int          idle_cycles;
  logic        calm;
  logic        hold_req;
  row_t        rows[$];

  waveform_table_generator i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [11:0] sample_index
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [16:0] sample_value
    .m_axis_tuser  (m_axis_tuser)    // [0] index_out_of_range
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Compute the sample the block owes for one index under the mirrored registers.
  function automatic sample_t wave_sample(input logic [11:0] idx);
    longint unsigned i, n, a, q, r, rp, x, x2, t, m, tip, span;
    longint          sum, low, v;
    sample_t         res;
    i = idx;
    n = (period_reg > MAX_PERIOD) ? MAX_PERIOD : period_reg;
    a = amp_reg;
    low = centered ? -longint'(a) : 0;
    res.oor = 1'b0;
    v = 0;
    if (i >= n) begin
      res.value = '0;
      res.oor = 1'b1;
      return res;
    end
    case (wave_sel)
      WF_SINE: begin
        q = (4 * i) / n;
        r = (4 * i) % n;
        rp = q[0] ? n - r : r;
        x = (longint'(HALF_PI_Q30) * rp) / n;
        x2 = (x * x) >> 30;
        t = x;
        sum = longint'(x);
        // Taylor terms through x^13, each step truncating
        for (int k = 1; k <= 6; k++) begin
          t = ((t * x2) >> 30) / ((2 * k) * (2 * k + 1));
          if (k % 2 == 1) sum = sum - longint'(t);
          else sum = sum + longint'(t);
        end
        if (sum < 0) sum = 0;
        m = (a * longint'(sum) + (64'd1 << 29)) >> 30;
        if (m > a) m = a;
        v = (q >= 2) ? -longint'(m) : longint'(m);
        if (!centered) v = v + longint'(a);
      end
      WF_SQUARE: begin
        v = (i < (n + 1) / 2) ? low + 2 * longint'(a) : low;
      end
      WF_TRI: begin
        tip = (2 * n + 5) / 10;
        span = 2 * a;
        if (i < tip) v = low + longint'((2 * span * i + tip) / (2 * tip));
        else v = low + longint'((2 * span * (n - i) + (n - tip)) / (2 * (n - tip)));
      end
      default: v = 0;
    endcase
    res.value = v[16:0];
    return res;
  endfunction

  // Observe all channels mid-cycle: inputs only change at the rising edge,
  // so whatever holds here is what the next edge accepts.
  always @(negedge clk_i) begin
    sample_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_count++;
        case (cfg_index_i)
          CFG_WAVEFORM:  wave_sel   = cfg_data_i[1:0];
          CFG_PERIOD:    period_reg = cfg_data_i[12:0];
          CFG_AMPLITUDE: amp_reg    = cfg_data_i[14:0];
          CFG_SIGNED:    centered   = cfg_data_i[0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        req_count++;
        sample_q.insert(sample_q.size(),
                        cur_typed ? cur_sample : wave_sample(s_axis_tdata[11:0]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        res_count++;
        if (sample_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("unexpected result value=%0d oor=%0b",
                     $signed(m_axis_tdata[16:0]), m_axis_tuser);
        end else begin
          want = sample_q.pop_front();
          if (m_axis_tdata[16:0] !== want.value || m_axis_tuser !== want.oor) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
              $display("mismatch: expected value=%0d oor=%0b, got value=%0d oor=%0b",
                       $signed(want.value), want.oor,
                       $signed(m_axis_tdata[16:0]), m_axis_tuser);
          end
        end
      end
      // watchdog: count cycles in which nothing moves
      if ((cfg_valid_i && cfg_ready_o) || (s_axis_tvalid && s_axis_tready)
          || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("watchdog expired with %0d results outstanding", sample_q.size());
          $display("tb: failure");
          $finish;
        end
      end
    end
  end

  // Receiver: stall a random number of cycles before each result.
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        // hold off long enough for the pipeline and output buffer to fill
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        stall = calm ? 0 : $urandom_range(0, 10);
        if (stall > 0) begin
          m_axis_tready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      m_axis_tready <= 1'b1;
      do @(negedge clk_i); while (!m_axis_tvalid);
      @(posedge clk_i);
    end
  end

  task automatic send_req(input logic [11:0] idx, input logic typed, input sample_t exp_s);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, idx};
    cur_typed  = typed;
    cur_sample = exp_s;
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
  endtask

  // Drop the request line and wait until every result is back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    wait (sample_q.size() == 0);
    repeat (TAIL_WAIT) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Append one row to the directed table.
  function automatic void add_row(input row_t r);
    rows.insert(rows.size(), r);
  endfunction

  function automatic row_t req_row(input logic [11:0] idx, input logic typed,
                                   input int value, input logic oor);
    row_t r;
    r.kind = ROW_REQ;
    r.cfg_reg = CFG_WAVEFORM;
    r.cfg_val = '0;
    r.index = idx;
    r.typed = typed;
    r.value = value;
    r.oor = oor;
    return r;
  endfunction

  function automatic row_t cfg_row(input logic [1:0] idx, input logic [15:0] val);
    row_t r;
    r = req_row('0, 1'b0, 0, 1'b0);
    r.kind = ROW_CFG;
    r.cfg_reg = idx;
    r.cfg_val = val;
    return r;
  endfunction

  initial begin
    sample_t     exp_s;
    int          n_eff;
    int          pick;
    int          n_reqs;
    logic [11:0] idx;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_WAVEFORM;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    wave_sel      = WF_SINE;
    period_reg    = RST_PERIOD;
    amp_reg       = RST_AMP;
    centered      = 1'b1;
    mismatches    = 0;
    req_count     = 0;
    res_count     = 0;
    cfg_count     = 0;
    idle_cycles   = 0;
    calm          = 1'b0;
    hold_req      = 1'b0;
    cur_typed     = 1'b0;
    cur_sample    = '{value: '0, oor: 1'b0};

    // directed table: reset defaults first, then register extremes
    add_row(req_row(12'd0, 1'b1, 0, 1'b0));
    add_row(req_row(12'd64, 1'b0, 0, 1'b0));
    add_row(req_row(12'd128, 1'b1, 0, 1'b0));
    add_row(req_row(12'd192, 1'b0, 0, 1'b0));
    add_row(req_row(12'd256, 1'b1, 0, 1'b1));
    add_row(req_row(12'd4095, 1'b1, 0, 1'b1));
    add_row(cfg_row(CFG_WAVEFORM, 16'(WF_SQUARE)));
    add_row(cfg_row(CFG_PERIOD, 16'd3));
    add_row(cfg_row(CFG_AMPLITUDE, 16'd32767));
    add_row(req_row(12'd0, 1'b1, 32767, 1'b0));
    add_row(req_row(12'd2, 1'b1, -32767, 1'b0));
    add_row(cfg_row(CFG_SIGNED, 16'd0));
    add_row(req_row(12'd1, 1'b1, 65534, 1'b0));
    add_row(req_row(12'd3, 1'b1, 0, 1'b1));
    add_row(cfg_row(CFG_WAVEFORM, 16'(WF_TRI)));
    add_row(req_row(12'd0, 1'b1, 0, 1'b0));
    add_row(cfg_row(CFG_PERIOD, 16'd2));       // tip collapses to zero
    add_row(req_row(12'd1, 1'b0, 0, 1'b0));
    add_row(cfg_row(CFG_PERIOD, 16'hFFFF));    // saturates to the maximum period
    add_row(req_row(12'd4095, 1'b0, 0, 1'b0));
    add_row(cfg_row(CFG_WAVEFORM, 16'd3));     // unused waveform code
    add_row(req_row(12'd7, 1'b1, 0, 1'b0));
    add_row(cfg_row(CFG_PERIOD, 16'd0));       // empty period: every index out of range
    add_row(req_row(12'd0, 1'b1, 0, 1'b1));
    add_row(cfg_row(CFG_WAVEFORM, 16'(WF_SINE)));
    add_row(cfg_row(CFG_PERIOD, 16'd4096));
    add_row(req_row(12'd1024, 1'b0, 0, 1'b0));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[k]) begin
      if (rows[k].kind == ROW_CFG) begin
        write_reg(rows[k].cfg_reg, rows[k].cfg_val);
      end else begin
        exp_s.value = rows[k].value[16:0];
        exp_s.oor = rows[k].oor;
        send_req(rows[k].index, rows[k].typed, exp_s);
      end
    end

    // random phases, each under a new register setting
    for (int ph = 0; ph < PHASES; ph++) begin
      calm = (ph == HOLD_PHASE);
      pick = $urandom_range(0, 9);
      write_reg(CFG_WAVEFORM, (pick == 0) ? 16'd3 : 16'($urandom_range(0, 2)));
      pick = $urandom_range(0, 9);
      case (pick)
        0: write_reg(CFG_PERIOD, 16'd3);
        1: write_reg(CFG_PERIOD, 16'd4096);
        2: write_reg(CFG_PERIOD, 16'($urandom_range(0, 16'hFFFF)));
        3, 4, 5: write_reg(CFG_PERIOD, 16'($urandom_range(3, 40)));
        default: write_reg(CFG_PERIOD, 16'($urandom_range(3, 4096)));
      endcase
      pick = $urandom_range(0, 5);
      case (pick)
        0: write_reg(CFG_AMPLITUDE, 16'd0);
        1: write_reg(CFG_AMPLITUDE, 16'd32767);
        default: write_reg(CFG_AMPLITUDE, 16'($urandom_range(0, 16'hFFFF)));
      endcase
      write_reg(CFG_SIGNED, 16'($urandom_range(0, 16'hFFFF)));
      n_eff = (period_reg > MAX_PERIOD) ? MAX_PERIOD : period_reg;
      // the back-to-back phase carries more requests than the block holds,
      // so the long receiver stall backs up into the input
      n_reqs = (ph == HOLD_PHASE) ? HOLD_REQS : PHASE_REQS;
      for (int j = 0; j < n_reqs; j++) begin
        if (ph == HOLD_PHASE && j == 0) hold_req = 1'b1;
        if (n_eff > 0 && $urandom_range(0, 7) != 0) idx = 12'($urandom_range(0, n_eff - 1));
        else idx = 12'($urandom_range(0, 4095));
        send_req(idx, 1'b0, cur_sample);
      end
    end

    drain();
    $display("covered %0d requests and %0d results over %0d register writes",
             req_count, res_count, cfg_count);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb: failure");
    end
    $finish;
  end

endmodule
